### rtl/core/mms_pkg.sv
// ----------------------------------------------------------------------------
// mms_pkg
// Shared types and constants of the multichannel moving sum unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mms_pkg;

    localparam int LANES               = 4;
    localparam int SAMPLE_W            = 12;
    localparam int SUM_W               = 17;
    localparam int WLEN_W              = 6;
    localparam int EN_W                = 4;
    localparam int WINDOW_MAX_DEF      = 32;
    localparam int ACTIVE_CHANNELS_DEF = 4;
    localparam int APB_ADDR_W          = 5;
    localparam int APB_DATA_W          = 32;
    localparam int REG_IDX_W           = 3;
    localparam int OUTQ_DEPTH          = 3;
    localparam int OUTQ_PTR_W          = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W          = $clog2(OUTQ_DEPTH + 1);

    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_ENABLE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN_CH0 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN_CH1 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN_CH2 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN_CH3 = 3'd4;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 6'd32;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [SUM_W-1:0]    sum_t;

    typedef struct packed {
        sample_t sample_ch3;
        sample_t sample_ch2;
        sample_t sample_ch1;
        sample_t sample_ch0;
    } in_t;

    typedef struct packed {
        sum_t sum_ch3;
        sum_t sum_ch2;
        sum_t sum_ch1;
        sum_t sum_ch0;
    } out_t;

    typedef struct packed {
        logic    push;
        sample_t sample;
    } lane_in_t;

endpackage

`default_nettype wire

### rtl/core/mms_ram.sv
// ----------------------------------------------------------------------------
// mms_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mms_ram #(
    parameter int WIDTH  = 12,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read at the written address returns the old word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/mms_lane.sv
// ----------------------------------------------------------------------------
// mms_lane
// One channel: ring head, sample ring in RAM and running window sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mms_lane #(
    parameter int WINDOW_MAX = mms_pkg::WINDOW_MAX_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mms_pkg::lane_in_t          lane_in,
    input  logic [mms_pkg::WLEN_W-1:0] win_len,
    output mms_pkg::sum_t              lane_sum
);

    import mms_pkg::*;

    localparam int HEAD_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CMP_W  = (HEAD_W + 1 > WLEN_W) ? HEAD_W + 1 : WLEN_W;

    logic [HEAD_W-1:0]   head_reg;
    logic [HEAD_W-1:0]   head_next;
    logic [HEAD_W:0]     nxt_wide;
    logic                wrap;
    logic [HEAD_W-1:0]   slot;
    logic [WINDOW_MAX-1:0] vld_reg;

    logic                push_reg;
    sample_t             new_reg;
    logic                old_vld_reg;
    sample_t             ram_rdata;
    sample_t             old_sample;
    sum_t                sum_reg;
    sum_t                sum_next;

    // slot selection for this transfer
    always_comb begin
        nxt_wide = {1'b0, head_reg} + (HEAD_W + 1)'(1);
        wrap     = (CMP_W'(nxt_wide) >= CMP_W'(win_len))
                || (nxt_wide >= (HEAD_W + 1)'(WINDOW_MAX));
        slot     = wrap ? '0 : nxt_wide[HEAD_W-1:0];
        head_next = lane_in.push ? slot : head_reg;
    end

    mms_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX),
        .ADDR_W(HEAD_W)
    ) u_ring (
        .aclk (aclk),
        .we   (lane_in.push),
        .waddr(slot),
        .wdata(lane_in.sample),
        .raddr(slot),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            vld_reg  <= '0;
            push_reg <= 1'b0;
        end else begin
            head_reg <= head_next;
            push_reg <= lane_in.push;
            if (lane_in.push) begin
                vld_reg[slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        new_reg     <= lane_in.sample;
        old_vld_reg <= vld_reg[slot];
    end

    // never-written slots read as zero
    assign old_sample = old_vld_reg ? ram_rdata : '0;

    always_comb begin
        if (push_reg) begin
            sum_next = sum_reg - SUM_W'(old_sample) + SUM_W'(new_reg);
        end else begin
            sum_next = sum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

    assign lane_sum = sum_next;

endmodule

`default_nettype wire

### rtl/core/mms_outq.sv
// ----------------------------------------------------------------------------
// mms_outq
// Merge of the lane sums into one result and a short output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mms_outq (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           push,
    input  mms_pkg::sum_t                  lane_sum [mms_pkg::LANES],
    output logic                           m_valid,
    input  logic                           m_ready,
    output mms_pkg::out_t                  m_data,
    output logic [mms_pkg::OUTQ_CNT_W-1:0] level
);

    import mms_pkg::*;

    out_t                  entry_reg [OUTQ_DEPTH];
    out_t                  merged;
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg;
    logic [OUTQ_PTR_W-1:0] wr_ptr_next;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg;
    logic [OUTQ_PTR_W-1:0] rd_ptr_next;
    logic [OUTQ_CNT_W-1:0] cnt_reg;
    logic [OUTQ_CNT_W-1:0] cnt_next;
    logic                  pop;

    always_comb begin
        merged.sum_ch0 = lane_sum[0];
        merged.sum_ch1 = lane_sum[1];
        merged.sum_ch2 = lane_sum[2];
        merged.sum_ch3 = lane_sum[3];
    end

    assign pop = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1))
                        ? '0 : wr_ptr_reg + OUTQ_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1))
                        ? '0 : rd_ptr_reg + OUTQ_PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + OUTQ_CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - OUTQ_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= merged;
        end
    end

    assign m_valid = (cnt_reg != '0);
    assign m_data  = entry_reg[rd_ptr_reg];
    assign level   = cnt_reg;

endmodule

`default_nettype wire

### rtl/core/multichannel_moving_sum_unit.sv
// ----------------------------------------------------------------------------
// multichannel_moving_sum_unit
// Four-channel moving window sum over ring buffers, one lane per channel.
// ----------------------------------------------------------------------------
// path: an input transfer goes through the ring RAM read, then the sum update
// into the output queue; one group per cycle while s_ready is high.
// throughput: each lane's ring RAM takes one read and one write per cycle.
// reset (aresetn low, synchronous): heads, sums, slot valid bits and output
// queue clear at once; no clearing pass, transfers are taken right after.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_moving_sum_unit #(
    parameter int WINDOW_MAX      = mms_pkg::WINDOW_MAX_DEF,
    parameter int ACTIVE_CHANNELS = mms_pkg::ACTIVE_CHANNELS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  mms_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output mms_pkg::out_t                  m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mms_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mms_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mms_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    import mms_pkg::*;

    logic [EN_W-1:0]      chan_en_reg;
    logic [WLEN_W-1:0]    win_len_reg [LANES];
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    logic                 s_xfer;
    logic                 p1_valid_reg;
    logic [OUTQ_CNT_W-1:0] q_level;
    sample_t              lane_sample [LANES];
    sum_t                 lane_sum [LANES];

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_en_reg <= '0;
            for (int i = 0; i < LANES; i++) begin
                win_len_reg[i] <= WLEN_RESET;
            end
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_CHANNEL_ENABLE: chan_en_reg    <= pwdata[EN_W-1:0];
                REG_WINDOW_LEN_CH0: win_len_reg[0] <= pwdata[WLEN_W-1:0];
                REG_WINDOW_LEN_CH1: win_len_reg[1] <= pwdata[WLEN_W-1:0];
                REG_WINDOW_LEN_CH2: win_len_reg[2] <= pwdata[WLEN_W-1:0];
                REG_WINDOW_LEN_CH3: win_len_reg[3] <= pwdata[WLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CHANNEL_ENABLE: prdata = APB_DATA_W'(chan_en_reg);
            REG_WINDOW_LEN_CH0: prdata = APB_DATA_W'(win_len_reg[0]);
            REG_WINDOW_LEN_CH1: prdata = APB_DATA_W'(win_len_reg[1]);
            REG_WINDOW_LEN_CH2: prdata = APB_DATA_W'(win_len_reg[2]);
            REG_WINDOW_LEN_CH3: prdata = APB_DATA_W'(win_len_reg[3]);
            default:            prdata = '0;
        endcase
    end

    // room for the transfer in flight plus this one
    assign s_ready = ((OUTQ_CNT_W + 1)'(q_level) + (OUTQ_CNT_W + 1)'(p1_valid_reg))
                   < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);
    assign s_xfer  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= s_xfer;
        end
    end

    assign lane_sample[0] = s_data.sample_ch0;
    assign lane_sample[1] = s_data.sample_ch1;
    assign lane_sample[2] = s_data.sample_ch2;
    assign lane_sample[3] = s_data.sample_ch3;

    for (genvar c = 0; c < LANES; c++) begin : g_lane
        if (c < ACTIVE_CHANNELS) begin : g_on
            lane_in_t lane_in;

            assign lane_in.push   = s_xfer && chan_en_reg[c];
            assign lane_in.sample = lane_sample[c];

            mms_lane #(
                .WINDOW_MAX(WINDOW_MAX)
            ) u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .lane_in (lane_in),
                .win_len (win_len_reg[c]),
                .lane_sum(lane_sum[c])
            );
        end else begin : g_off
            assign lane_sum[c] = '0;
        end
    end

    mms_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (p1_valid_reg),
        .lane_sum(lane_sum),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .level   (q_level)
    );

endmodule

`default_nettype wire

### rtl/core/mms_checker.sv
// ----------------------------------------------------------------------------
// mms_checker
// Port-level checks of the multichannel moving sum unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mms_checker #(
    parameter int WINDOW_MAX = mms_pkg::WINDOW_MAX_DEF
) (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input mms_pkg::out_t m_data,
    input logic          pready
);

    import mms_pkg::*;

    localparam longint SUM_MAX = longint'(WINDOW_MAX) * ((longint'(1) << SAMPLE_W) - 1);

    logic s_xfer;
    assign s_xfer = s_valid && s_ready;

    a_pready_high: assert property (@(posedge aclk) pready)
        else $error("pready dropped");

    a_empty_after_reset: assert property (@(posedge aclk) $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid && !s_xfer && !$past(s_xfer)) |=> !m_valid)
        else $error("result without a matching input transfer");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

    if (SUM_MAX < (longint'(1) << SUM_W)) begin : g_bound
        a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
            m_valid |-> (longint'(m_data.sum_ch0) <= SUM_MAX
                      && longint'(m_data.sum_ch1) <= SUM_MAX
                      && longint'(m_data.sum_ch2) <= SUM_MAX
                      && longint'(m_data.sum_ch3) <= SUM_MAX))
            else $error("window sum above full-scale window");
    end

endmodule

bind multichannel_moving_sum_unit mms_checker #(
    .WINDOW_MAX(WINDOW_MAX)
) u_mms_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data),
    .pready (pready)
);

`default_nettype wire
